// ===== rtl/cprb_pkg.sv =====
// Shared codes, constants and command/result types of the chunked playback ring buffer.
`timescale 1ns / 1ps

package cprb_pkg;

  localparam int REQ_W    = 2;
  localparam int DATA_W   = 8;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 10;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_POW2  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RUN_DRY   = 3'd5;

  // Queue depths between the parts of the block.
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_WRITE,
    CMD_CHUNK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_space;
    logic [DATA_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   out_byte;
    logic [FREE_W-1:0]   free_space;
    logic                last;
  } res_t;

endpackage

// ===== rtl/cprb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cprb_fifo.sv =====
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps

module cprb_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  T                mem_q [DEPTH];
  logic [IW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/cprb_front.sv =====
// Front part: accepts requests, tracks both pointers and classifies each request.
`timescale 1ns / 1ps

module cprb_front #(
  parameter int BUF_BYTES   = 1024,
  parameter int CHUNK_BYTES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [cprb_pkg::REQ_W-1:0]      req_type_i,
  input  logic [cprb_pkg::DATA_W-1:0]     data_byte_i,
  input  logic [cprb_pkg::SIZE_W-1:0]     block_size_i,
  input  logic                            cmd_full_i,
  output logic                            cmd_push_o,
  output cprb_pkg::cmd_t                  cmd_o
);

  import cprb_pkg::*;

  localparam int AW    = $clog2(BUF_BYTES);
  localparam int SW    = AW + 1;
  localparam int CMP_W = (SW > SIZE_W) ? SW : SIZE_W;

  localparam logic [SW-1:0]    BUF_SUM   = SW'(BUF_BYTES);
  localparam logic [SW-1:0]    CHUNK_SUM = SW'(CHUNK_BYTES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(BUF_BYTES - 1);
  localparam logic [AW-1:0]    RP_RESET  = AW'(CHUNK_BYTES % BUF_BYTES);
  localparam logic [CMP_W-1:0] BUF_CMP   = CMP_W'(BUF_BYTES);

  logic [AW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [SW-1:0]     free_full, rp_sum;
  logic [AW-1:0]     rp_next;
  logic [SIZE_W-1:0] size_m1;
  logic [FREE_W-1:0] free_sp;
  logic              accept, dry, cmd_valid;

  assign accept = push_i && !cmd_full_i;

  always_comb begin
    if (wp_q > rp_q) begin
      free_full = {1'b0, rp_q} + BUF_SUM - {1'b0, wp_q};
    end else if (wp_q < rp_q) begin
      free_full = {1'b0, rp_q} - {1'b0, wp_q};
    end else begin
      free_full = '0;
    end
  end

  assign free_sp = FREE_W'(free_full);
  assign size_m1 = block_size_i - 1'b1;
  assign rp_sum  = {1'b0, rp_q} + CHUNK_SUM;
  assign rp_next = (rp_sum >= BUF_SUM) ? '0 : rp_sum[AW-1:0];
  assign dry     = (rp_next == wp_q);

  always_comb begin
    cmd_valid        = 1'b0;
    cmd_o.kind       = CMD_RESULT;
    cmd_o.status     = ST_OK;
    cmd_o.free_space = free_sp;
    cmd_o.data       = data_byte_i;
    wp_d             = wp_q;
    rp_d             = rp_q;
    case (req_type_i)
      REQ_CHECK: begin
        cmd_valid = 1'b1;
        if ((block_size_i & size_m1) != '0) begin
          cmd_o.status = ST_NOT_POW2;
        end else if (CMP_W'(block_size_i) >= BUF_CMP) begin
          cmd_o.status = ST_TOO_LARGE;
        end else if (CMP_W'(free_full) >= CMP_W'(block_size_i)) begin
          cmd_o.status = ST_OK;
        end else begin
          cmd_o.status = ST_NO_SPACE;
        end
      end
      REQ_WRITE: begin
        cmd_valid = 1'b1;
        if (free_full == '0) begin
          cmd_o.status = ST_OVERFLOW;
        end else begin
          cmd_o.kind = CMD_WRITE;
          wp_d       = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
        end
      end
      REQ_READ: begin
        cmd_valid  = 1'b1;
        cmd_o.kind = CMD_CHUNK;
        if (dry) begin
          cmd_o.status = ST_RUN_DRY;
        end else begin
          rp_d = rp_next;
        end
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept && cmd_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= RP_RESET;
    end else if (accept) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

// ===== rtl/cprb_back.sv =====
// Back part: carries out writes and chunk reads on the sample store and forms the results.
`timescale 1ns / 1ps

module cprb_back #(
  parameter int BUF_BYTES   = 1024,
  parameter int CHUNK_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_empty_i,
  input  cprb_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  input  logic [cprb_pkg::OUT_CNT_W-1:0] res_count_i,
  output logic                           res_push_o,
  output cprb_pkg::res_t                 res_o
);

  import cprb_pkg::*;

  localparam int AW   = $clog2(BUF_BYTES);
  localparam int SW   = AW + 1;
  localparam int IDXW = $clog2(CHUNK_BYTES);

  localparam logic [SW-1:0]          BUF_SUM   = SW'(BUF_BYTES);
  localparam logic [SW-1:0]          CHUNK_SUM = SW'(CHUNK_BYTES);
  localparam logic [AW-1:0]          LAST_ADDR = AW'(BUF_BYTES - 1);
  localparam logic [AW-1:0]          RP_RESET  = AW'(CHUNK_BYTES % BUF_BYTES);
  localparam logic [IDXW-1:0]        LAST_IDX  = IDXW'(CHUNK_BYTES - 1);
  localparam logic [OUT_CNT_W:0]     OUT_LIMIT = (OUT_CNT_W + 1)'(OUT_DEPTH);

  typedef enum logic {
    BK_IDLE,
    BK_CHUNK
  } back_state_e;

  back_state_e         state_q;
  logic [AW-1:0]       wp_q, rp_q, addr_q;
  logic                wrapped_q;
  logic [IDXW-1:0]     idx_q;
  logic [STATUS_W-1:0] chunk_status_q;
  logic [FREE_W-1:0]   chunk_free_q;

  // Second stage: result fields waiting for the store's read data.
  logic                s2_valid_q, s2_read_q, s2_known_q, s2_last_q;
  logic [STATUS_W-1:0] s2_status_q;
  logic [FREE_W-1:0]   s2_free_q;

  logic [SW-1:0]       rp_sum;
  logic [AW-1:0]       rp_next, addr_inc, wp_inc;
  logic                room, issue, last_byte, ram_we;
  logic [DATA_W-1:0]   ram_rdata;

  // Room counts the result already in the second stage so the queue never overflows.
  assign room      = ({1'b0, res_count_i} + {{OUT_CNT_W{1'b0}}, s2_valid_q}) < OUT_LIMIT;
  assign cmd_pop_o = (state_q == BK_IDLE) && !cmd_empty_i && room;
  assign issue     = (state_q == BK_CHUNK) && room;
  assign last_byte = (idx_q == LAST_IDX);
  assign ram_we    = cmd_pop_o && (cmd_i.kind == CMD_WRITE);

  assign rp_sum   = {1'b0, rp_q} + CHUNK_SUM;
  assign rp_next  = (rp_sum >= BUF_SUM) ? '0 : rp_sum[AW-1:0];
  assign addr_inc = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
  assign wp_inc   = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;

  cprb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(BUF_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(cmd_i.data),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      wp_q           <= '0;
      rp_q           <= RP_RESET;
      addr_q         <= '0;
      wrapped_q      <= 1'b0;
      idx_q          <= '0;
      chunk_status_q <= ST_OK;
      chunk_free_q   <= '0;
      s2_valid_q     <= 1'b0;
      s2_read_q      <= 1'b0;
      s2_known_q     <= 1'b0;
      s2_last_q      <= 1'b0;
      s2_status_q    <= ST_OK;
      s2_free_q      <= '0;
    end else begin
      s2_valid_q <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (cmd_pop_o) begin
            case (cmd_i.kind)
              CMD_CHUNK: begin
                state_q        <= BK_CHUNK;
                addr_q         <= rp_q;
                idx_q          <= '0;
                chunk_status_q <= cmd_i.status;
                chunk_free_q   <= cmd_i.free_space;
              end
              default: begin
                if (cmd_i.kind == CMD_WRITE) begin
                  wp_q <= wp_inc;
                  if (wp_q == LAST_ADDR) begin
                    wrapped_q <= 1'b1;
                  end
                end
                s2_valid_q  <= 1'b1;
                s2_read_q   <= 1'b0;
                s2_known_q  <= 1'b0;
                s2_last_q   <= 1'b1;
                s2_status_q <= cmd_i.status;
                s2_free_q   <= cmd_i.free_space;
              end
            endcase
          end
        end
        BK_CHUNK: begin
          if (issue) begin
            // Bytes that were never written since reset are masked to zero on the output.
            s2_valid_q  <= 1'b1;
            s2_read_q   <= 1'b1;
            s2_known_q  <= wrapped_q || (addr_q < wp_q);
            s2_last_q   <= last_byte;
            s2_status_q <= chunk_status_q;
            s2_free_q   <= chunk_free_q;
            addr_q      <= addr_inc;
            idx_q       <= idx_q + 1'b1;
            if (last_byte) begin
              state_q <= BK_IDLE;
              if (chunk_status_q != ST_RUN_DRY) begin
                rp_q <= rp_next;
              end
            end
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
    end
  end

  assign res_push_o       = s2_valid_q;
  assign res_o.status     = s2_status_q;
  assign res_o.out_byte   = (s2_read_q && s2_known_q) ? ram_rdata : '0;
  assign res_o.free_space = s2_free_q;
  assign res_o.last       = s2_last_q;

endmodule

// ===== rtl/chunked_playback_ring_buffer.sv =====
// Top level: byte ring buffer for audio playback with queue interfaces on both sides.
// A check or write result passes the command queue, the back's second stage and the result
// queue; a chunk's first byte also passes the back state register before that stage. The back
// part takes one check or write per cycle while the result queue has room; a chunk read keeps
// it busy up to its last byte, one byte per cycle while there is room. The input side stalls
// only on a full queue. Reset zeroes the write pointer, sets the read pointer to CHUNK_BYTES,
// empties all queues; bytes unwritten since reset read as zero, so no clearing is needed.
`timescale 1ns / 1ps

module chunked_playback_ring_buffer #(
  parameter int BUF_BYTES   = 1024,
  parameter int CHUNK_BYTES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [cprb_pkg::REQ_W-1:0]       req_type_i,
  input  logic [cprb_pkg::DATA_W-1:0]      data_byte_i,
  input  logic [cprb_pkg::SIZE_W-1:0]      block_size_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [cprb_pkg::STATUS_W-1:0]    status_o,
  output logic [cprb_pkg::DATA_W-1:0]      out_byte_o,
  output logic [cprb_pkg::FREE_W-1:0]      free_space_o,
  output logic                             last_o
);

  import cprb_pkg::*;

  logic                 cmd_push, cmd_pop, cmd_empty;
  cmd_t                 cmd_in, cmd_out;
  logic                 res_push;
  res_t                 res_in, res_out;
  logic [OUT_CNT_W-1:0] res_count;

  cprb_front #(
    .BUF_BYTES  (BUF_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .block_size_i(block_size_i),
    .cmd_full_i  (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  cprb_fifo #(
    .T    (cmd_t),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty),
    .count_o()
  );

  cprb_back #(
    .BUF_BYTES  (BUF_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  cprb_fifo #(
    .T    (res_t),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign status_o     = res_out.status;
  assign out_byte_o   = res_out.out_byte;
  assign free_space_o = res_out.free_space;
  assign last_o       = res_out.last;

endmodule
